[design/lzd2_pkg.sv]
// Shared types and constants for the level-2 LZ77 decompressor.
// No dependencies; imported by every module of the block.
package lzd2_pkg;

  // Parser phase of the compressed stream
  typedef enum logic [2:0] {
    PH_FIRST,
    PH_CTRL,
    PH_LIT,
    PH_LEN,
    PH_CODE,
    PH_FARHI,
    PH_FARLO,
    PH_COPY
  } lzd2_phase_e;

  // Sticky error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_REF    = 3'd1;
  localparam logic [2:0] ERR_SIZE   = 3'd2;
  localparam logic [2:0] ERR_TRUNC  = 3'd3;
  localparam logic [2:0] ERR_OPCODE = 3'd4;

  // Item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_COPY = 1'b1;

  // Register index (word address bit 2)
  localparam logic REG_OUTPUT_SIZE = 1'b0;

  // Token format constants
  localparam logic [2:0]  LEN_EXT    = 3'd6;        // length field that chains extra bytes
  localparam logic [7:0]  BYTE_ALL1  = 8'hFF;
  localparam logic [16:0] FAR_MARK   = 17'h01F00;   // distance high bits that flag far form
  localparam logic [16:0] FAR_BIAS   = 17'd8191;
  localparam logic [31:0] MATCH_BIAS = 32'd3;

  // Result word buffer depth
  localparam int unsigned OUTBUF_DEPTH = 3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_byte;
    logic       in_last;
  } lzd2_in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic       done_res;
    logic [2:0] error;
  } lzd2_res_t;

  // Parser to history stage: everything but the copied byte value
  typedef struct packed {
    logic       out_valid;
    logic       from_hist;
    logic [7:0] lit_byte;
    logic       copy_pending;
    logic       done_res;
    logic [2:0] error;
  } lzd2_issue_t;

endpackage

[design/lzd2_parser.sv]
// Token parser: control state of the decompressor, one word per cycle while accept_i is high.
// Depends on lzd2_pkg; drives history read/write addresses for lzd2_history.
module lzd2_parser #(
  parameter int unsigned WINDOW_BYTES = 131072,
  localparam int unsigned AW = $clog2(WINDOW_BYTES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  lzd2_pkg::lzd2_in_t   in_word_i,
  input  logic [31:0]          output_size_i,
  output lzd2_pkg::lzd2_issue_t issue_o,
  output logic [AW-1:0]        rd_addr_o,
  output logic [AW-1:0]        wr_addr_o
);
  import lzd2_pkg::*;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  lzd2_phase_e   phase_q, phase_d;
  logic [31:0]   bytes_q, bytes_d;
  logic [31:0]   len_q, len_d;
  logic [16:0]   dist_q, dist_d;
  logic [5:0]    lit_q, lit_d;
  logic [2:0]    err_q, err_d;
  logic          ended_q, ended_d;
  logic          done_q, done_d;
  logic [AW-1:0] ptr_q, ptr_d;

  logic          active;
  logic [7:0]    b;
  logic          last;
  logic [7:0]    c;
  logic [31:0]   bytes_inc;
  logic [AW-1:0] ptr_inc;
  logic [AW-1:0] dist_ext;
  logic [32:0]   lit_sum;
  logic [31:0]   len_b;
  logic [31:0]   len_3;
  logic [16:0]   near_dist;
  logic [16:0]   far_dist;
  logic [16:0]   chk_dist;
  logic [31:0]   chk_len;
  logic          chk_over;
  logic          chk_ref;
  logic          fin_ok;
  logic          out_vld;
  logic          from_hist;

  assign b    = in_word_i.in_byte;
  assign last = in_word_i.in_last;

  // Datapath terms shared by the phases
  always_comb begin
    active    = (err_q == ERR_NONE) && !done_q;
    c         = (phase_q == PH_FIRST) ? {3'b000, b[4:0]} : b;
    bytes_inc = bytes_q + 32'd1;
    ptr_inc   = (ptr_q == AW'(WINDOW_BYTES - 1)) ? '0 : ptr_q + AW'(1);
    lit_sum   = {1'b0, bytes_q} + 33'(c) + 33'd1;
    len_b     = sat_add(len_q, {24'b0, b});
    len_3     = sat_add(len_q, MATCH_BIAS);
    near_dist = dist_q + 17'(b) + 17'd1;
    far_dist  = {dist_q[16:8], b} + FAR_BIAS + 17'd1;
    chk_dist  = (phase_q == PH_FARLO) ? far_dist : near_dist;
    chk_len   = (phase_q == PH_CODE) ? len_3 : len_q;
    chk_over  = ({1'b0, bytes_q} + {1'b0, chk_len}) > {1'b0, output_size_i};
    chk_ref   = {15'b0, chk_dist} > bytes_q;
    fin_ok    = bytes_inc == output_size_i;
    dist_ext  = AW'(dist_q);
  end

  // Copy source in the circular window
  always_comb begin
    if (ptr_q >= dist_ext) begin
      rd_addr_o = ptr_q - dist_ext;
    end else begin
      rd_addr_o = ptr_q + AW'(WINDOW_BYTES) - dist_ext;
    end
  end

  assign wr_addr_o = ptr_q;

  // Next state of the parser
  always_comb begin
    phase_d   = phase_q;
    bytes_d   = bytes_q;
    len_d     = len_q;
    dist_d    = dist_q;
    lit_d     = lit_q;
    err_d     = err_q;
    ended_d   = ended_q;
    done_d    = done_q;
    ptr_d     = ptr_q;
    out_vld   = 1'b0;
    from_hist = 1'b0;
    if (active) begin
      if (phase_q == PH_COPY) begin
        if (in_word_i.opcode != OP_COPY) begin
          err_d = ERR_OPCODE;
        end else begin
          out_vld   = 1'b1;
          from_hist = 1'b1;
          bytes_d   = bytes_inc;
          ptr_d     = ptr_inc;
          len_d     = len_q - 32'd1;
          if (len_q == 32'd1) begin
            phase_d = PH_CTRL;
            if (ended_q) begin
              if (fin_ok) done_d = 1'b1;
              else        err_d  = ERR_TRUNC;
            end
          end
        end
      end else if (in_word_i.opcode != OP_BYTE) begin
        err_d = ERR_OPCODE;
      end else begin
        unique case (phase_q)
          PH_FIRST, PH_CTRL: begin
            if (c[7:5] == 3'b000) begin
              if (lit_sum > {1'b0, output_size_i}) begin
                err_d = ERR_SIZE;
              end else begin
                lit_d   = {1'b0, c[4:0]} + 6'd1;
                phase_d = PH_LIT;
              end
            end else begin
              len_d   = {29'b0, c[7:5] - 3'd1};
              dist_d  = {4'b0, c[4:0], 8'b0};
              phase_d = ((c[7:5] - 3'd1) == LEN_EXT) ? PH_LEN : PH_CODE;
            end
            if (last && (err_d == ERR_NONE)) err_d = ERR_TRUNC;
          end
          PH_LIT: begin
            out_vld = 1'b1;
            bytes_d = bytes_inc;
            ptr_d   = ptr_inc;
            lit_d   = lit_q - 6'd1;
            if (lit_q == 6'd1) begin
              phase_d = PH_CTRL;
              if (last) begin
                if (fin_ok) done_d = 1'b1;
                else        err_d  = ERR_TRUNC;
              end
            end else if (last) begin
              err_d = ERR_TRUNC;
            end
          end
          PH_LEN: begin
            len_d = len_b;
            if (b != BYTE_ALL1) phase_d = PH_CODE;
            if (last) err_d = ERR_TRUNC;
          end
          PH_CODE, PH_FARLO: begin
            len_d = chk_len;
            if ((phase_q == PH_CODE) && (b == BYTE_ALL1) && (dist_q == FAR_MARK)) begin
              phase_d = PH_FARHI;
              if (last) err_d = ERR_TRUNC;
            end else begin
              dist_d = chk_dist;
              if (chk_over) begin
                err_d = ERR_SIZE;
              end else if (chk_ref) begin
                err_d = ERR_REF;
              end else begin
                phase_d = PH_COPY;
                ended_d = last;
              end
            end
          end
          PH_FARHI: begin
            dist_d  = {1'b0, b, 8'b0};
            phase_d = PH_FARLO;
            if (last) err_d = ERR_TRUNC;
          end
          default: ;
        endcase
      end
    end
  end

  // Result fields known at accept time
  always_comb begin
    issue_o.out_valid    = out_vld;
    issue_o.from_hist    = from_hist;
    issue_o.lit_byte     = b;
    issue_o.copy_pending = (err_d == ERR_NONE) && !done_d && (phase_d == PH_COPY);
    issue_o.done_res     = (err_d == ERR_NONE) && done_d;
    issue_o.error        = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      bytes_q <= '0;
      len_q   <= '0;
      dist_q  <= '0;
      lit_q   <= '0;
      err_q   <= ERR_NONE;
      ended_q <= 1'b0;
      done_q  <= 1'b0;
      ptr_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      bytes_q <= bytes_d;
      len_q   <= len_d;
      dist_q  <= dist_d;
      lit_q   <= lit_d;
      err_q   <= err_d;
      ended_q <= ended_d;
      done_q  <= done_d;
      ptr_q   <= ptr_d;
    end
  end

endmodule

[design/lzd2_history.sv]
// History window RAM and the stage that resolves each output byte.
// Depends on lzd2_pkg; fed by lzd2_parser, feeds lzd2_outbuf.
module lzd2_history #(
  parameter int unsigned WINDOW_BYTES = 131072,
  localparam int unsigned AW = $clog2(WINDOW_BYTES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  lzd2_pkg::lzd2_issue_t issue_i,
  input  logic [AW-1:0]         rd_addr_i,
  input  logic [AW-1:0]         wr_addr_i,
  output logic                  s1_valid_o,
  output lzd2_pkg::lzd2_res_t   res_o
);
  import lzd2_pkg::*;

  logic [7:0]    mem [WINDOW_BYTES];

  logic          s1_valid_q;
  lzd2_issue_t   s1_q;
  logic [AW-1:0] waddr_q;
  logic [7:0]    rdata_q;
  logic [7:0]    fwd_q;
  logic          fwd_sel_q;

  logic [7:0]    hist_byte;
  logic [7:0]    s1_byte;
  logic          wen;
  logic          fwd_hit;

  // Byte of the word in this stage; a read that missed last cycle's write is bypassed
  assign hist_byte = fwd_sel_q ? fwd_q : rdata_q;
  assign s1_byte   = s1_q.from_hist ? hist_byte : s1_q.lit_byte;
  assign wen       = s1_valid_q && s1_q.out_valid;
  assign fwd_hit   = wen && (waddr_q == rd_addr_i);

  // Window RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr_q] <= s1_byte;
    if (accept_i) rdata_q <= mem[rd_addr_i];
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q      <= issue_i;
      waddr_q   <= wr_addr_i;
      fwd_sel_q <= fwd_hit;
      fwd_q     <= s1_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  assign s1_valid_o = s1_valid_q;

  always_comb begin
    res_o.out_valid    = s1_q.out_valid;
    res_o.out_byte     = s1_q.out_valid ? s1_byte : 8'h00;
    res_o.copy_pending = s1_q.copy_pending;
    res_o.done_res     = s1_q.done_res;
    res_o.error        = s1_q.error;
  end

endmodule

[design/lzd2_outbuf.sv]
// Result word buffer between the history stage and the output channel.
// Depends on lzd2_pkg; depth OUTBUF_DEPTH words.
module lzd2_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lzd2_pkg::lzd2_res_t push_word_i,
  input  logic                stall_i,
  output logic                valid_o,
  output lzd2_pkg::lzd2_res_t word_o,
  output logic [1:0]          count_o
);
  import lzd2_pkg::*;

  lzd2_res_t  buf_q [OUTBUF_DEPTH];
  logic [1:0] wr_q, rd_q, cnt_q;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && !stall_i;
  assign valid_o = cnt_q != 2'd0;
  assign word_o  = buf_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= push_word_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == 2'(OUTBUF_DEPTH - 1)) ? 2'd0 : wr_q + 2'd1;
      if (pop)    rd_q <= (rd_q == 2'(OUTBUF_DEPTH - 1)) ? 2'd0 : rd_q + 2'd1;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[design/lz77_level2_decompressor_top.sv]
// Top level of the level-2 LZ77 decompressor with its register port.
// Depends on lzd2_pkg, lzd2_parser, lzd2_history and lzd2_outbuf.
//
// Takes one input word per cycle while in_stall_o is low and returns exactly one result
// word for each, through the history stage register and the result buffer. Words
// can follow back to back, including match copies at distance one: the history
// RAM has one write port and one registered read port, and a byte written in
// the cycle of a read is bypassed to it. A three-word result buffer lets input
// continue while a result waits. The history window holds no reset state and
// needs no clearing pass; the stream never refers before its first byte.
// Write output_size only while no word is in flight.
module lz77_level2_decompressor_top #(
  parameter int unsigned WINDOW_BYTES = 131072
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lzd2_pkg::lzd2_in_t  in_word_i,
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output lzd2_pkg::lzd2_res_t res_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lzd2_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  logic          accept;
  logic [31:0]   output_size_q;
  lzd2_issue_t   issue;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          s1_valid;
  lzd2_res_t     s1_res;
  logic [1:0]    buf_count;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUTPUT_SIZE) ? output_size_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_size_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_OUTPUT_SIZE)) begin
      output_size_q <= pwdata;
    end
  end

  // Accept only while the buffer has room for every word in flight
  assign in_stall_o = ({1'b0, buf_count} + {2'b0, s1_valid}) >= 3'(OUTBUF_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  lzd2_parser #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_word_i     (in_word_i),
    .output_size_i (output_size_q),
    .issue_o       (issue),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr)
  );

  lzd2_history #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .issue_i    (issue),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .s1_valid_o (s1_valid),
    .res_o      (s1_res)
  );

  lzd2_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid),
    .push_word_i (s1_res),
    .stall_i     (res_stall_i),
    .valid_o     (res_valid_o),
    .word_o      (res_word_o),
    .count_o     (buf_count)
  );

endmodule

[sim/lzd2_checker.sv]
// Checker for the level-2 LZ77 decompressor: watches the input, result and register
// channels, predicts every result word and compares it. Depends on lzd2_pkg.
module lzd2_checker #(
  parameter int unsigned WINDOW_BYTES = 131072
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  lzd2_pkg::lzd2_in_t  in_word_i,
  input  logic                res_valid_i,
  input  logic                res_stall_i,
  input  lzd2_pkg::lzd2_res_t res_word_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lzd2_pkg::*;

  // Predictor state
  lzd2_phase_e phase;
  logic [31:0] out_size;
  logic [31:0] produced;
  logic [31:0] mlen;
  logic [16:0] mdist;
  logic [5:0]  lit_left;
  logic [2:0]  err;
  logic        ended;
  logic        done_q;
  logic [7:0]  hist_mem [WINDOW_BYTES];

  lzd2_res_t expected_results [$];

  initial fail_count_o = 0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic flag_failure(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic store_byte(logic [7:0] b);
    hist_mem[produced % WINDOW_BYTES] = b;
    produced++;
  endtask

  // Stream end: done on an exact size, truncated otherwise
  task automatic close_stream();
    if (produced == out_size) done_q = 1'b1;
    else err = ERR_TRUNC;
  endtask

  // Match header complete: size first, then the back reference
  task automatic accept_match(logic last);
    if ({1'b0, produced} + {1'b0, mlen} > {1'b0, out_size}) err = ERR_SIZE;
    else if (32'(mdist) > produced) err = ERR_REF;
    else begin
      phase = PH_COPY;
      ended = last;
    end
  endtask

  // Advance the predicted decoder by one input word and form its result word
  task automatic decode_word(input lzd2_in_t w, output lzd2_res_t r);
    logic [7:0] c;
    logic [7:0] ob;
    logic       ov;
    longint     src;
    ov = 1'b0;
    ob = 8'h00;
    if (err == ERR_NONE && !done_q) begin
      if (phase == PH_COPY) begin
        if (w.opcode != OP_COPY) err = ERR_OPCODE;
        else begin
          src = (longint'(produced) + WINDOW_BYTES - longint'(mdist)) % WINDOW_BYTES;
          ob = hist_mem[src];
          ov = 1'b1;
          store_byte(ob);
          mlen--;
          if (mlen == 0) begin
            phase = PH_CTRL;
            if (ended) close_stream();
          end
        end
      end else if (w.opcode != OP_BYTE) begin
        err = ERR_OPCODE;
      end else begin
        case (phase)
          PH_FIRST, PH_CTRL: begin
            c = (phase == PH_FIRST) ? {3'b000, w.in_byte[4:0]} : w.in_byte;
            if (c < 8'd32) begin
              if ({1'b0, produced} + 33'(c) + 33'd1 > {1'b0, out_size}) err = ERR_SIZE;
              else begin
                lit_left = 6'(c + 8'd1);
                phase = PH_LIT;
              end
            end else begin
              mlen = 32'(c[7:5]) - 32'd1;
              mdist = 17'(c[4:0]) << 8;
              phase = (mlen == 32'(LEN_EXT)) ? PH_LEN : PH_CODE;
            end
            if (err == ERR_NONE && w.in_last) err = ERR_TRUNC;
          end
          PH_LIT: begin
            ob = w.in_byte;
            ov = 1'b1;
            store_byte(ob);
            lit_left--;
            if (lit_left == 0) begin
              phase = PH_CTRL;
              if (w.in_last) close_stream();
            end else if (w.in_last) begin
              err = ERR_TRUNC;
            end
          end
          PH_LEN: begin
            mlen = sat_add(mlen, 32'(w.in_byte));
            if (w.in_byte != BYTE_ALL1) phase = PH_CODE;
            if (w.in_last) err = ERR_TRUNC;
          end
          PH_CODE: begin
            mlen = sat_add(mlen, MATCH_BIAS);
            if (w.in_byte == BYTE_ALL1 && mdist == FAR_MARK) begin
              phase = PH_FARHI;
              if (w.in_last) err = ERR_TRUNC;
            end else begin
              mdist = mdist + 17'(w.in_byte) + 17'd1;
              accept_match(w.in_last);
            end
          end
          PH_FARHI: begin
            mdist = {1'b0, w.in_byte, 8'h00};
            phase = PH_FARLO;
            if (w.in_last) err = ERR_TRUNC;
          end
          PH_FARLO: begin
            mdist = (mdist | 17'(w.in_byte)) + FAR_BIAS + 17'd1;
            accept_match(w.in_last);
          end
          default: ;
        endcase
      end
    end
    r.out_valid    = ov;
    r.out_byte     = ov ? ob : 8'h00;
    r.copy_pending = (err == ERR_NONE && !done_q && phase == PH_COPY);
    r.done_res     = (err == ERR_NONE && done_q);
    r.error        = err;
  endtask

  // Channel monitor: results first, then register access, then new input words
  always @(posedge clk_i or negedge rst_ni) begin
    lzd2_res_t want;
    lzd2_res_t got;
    if (!rst_ni) begin
      phase    = PH_FIRST;
      out_size = '0;
      produced = '0;
      mlen     = '0;
      mdist    = '0;
      lit_left = '0;
      err      = ERR_NONE;
      ended    = 1'b0;
      done_q   = 1'b0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        got = res_word_i;
        if (expected_results.size() == 0) begin
          flag_failure($sformatf("result word with nothing expected: valid=%0b byte=%02h err=%0d",
                                 got.out_valid, got.out_byte, got.error));
        end else begin
          want = expected_results.pop_front();
          if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
              got.copy_pending !== want.copy_pending || got.done_res !== want.done_res ||
              got.error !== want.error)
            flag_failure($sformatf({"result mismatch: expected valid=%0b byte=%02h pend=%0b ",
                                    "done=%0b err=%0d, got valid=%0b byte=%02h pend=%0b ",
                                    "done=%0b err=%0d"},
                                   want.out_valid, want.out_byte, want.copy_pending,
                                   want.done_res, want.error, got.out_valid, got.out_byte,
                                   got.copy_pending, got.done_res, got.error));
        end
      end
      if (psel && penable && pready && paddr[2] == REG_OUTPUT_SIZE) begin
        if (pwrite) out_size = pwdata;
        else if (prdata !== out_size)
          flag_failure($sformatf("output_size read: expected %08h, got %08h", out_size, prdata));
      end
      if (in_valid_i && !in_stall_i) begin
        decode_word(in_word_i, want);
        expected_results.push_back(want);
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

[sim/tb_lz77_level2_decompressor_top.sv]
// Testbench top for the level-2 LZ77 decompressor: clock, reset, register writes and
// compressed stream stimulus. Depends on lzd2_pkg, lzd2_checker and the block's RTL.
module tb_lz77_level2_decompressor_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lzd2_pkg::*;

  localparam logic [2:0] ADDR_OUTPUT_SIZE = {REG_OUTPUT_SIZE, 2'b00};

  typedef enum {
    END_DONE_LIT,
    END_DONE_MATCH,
    END_SHORT,
    END_OVERRUN,
    END_BAD_REF,
    END_TRUNC,
    END_BAD_OP
  } ending_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  lzd2_in_t    in_word_i   = '0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  lzd2_res_t   res_word_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;

  // Stream bookkeeping on the sender side
  int unsigned n_sent   = 0;
  int unsigned produced = 0;
  bit          quiet    = 1'b0;
  bit          first_token = 1'b1;

  lz77_level2_decompressor_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .res_valid_o, .res_stall_i, .res_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lzd2_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .res_valid_i(res_valid_o), .res_stall_i, .res_word_i(res_word_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side backpressure
  always @(posedge clk_i) begin
    res_stall_i <= !quiet && ($urandom_range(99) < 37);
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  // One input word; returns right after the edge that took it
  task automatic send_word(logic op, logic [7:0] b, logic last);
    if (!quiet) begin
      while ($urandom_range(99) < 37) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{opcode: op, in_byte: b, in_last: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  // Hold the sender until every result word is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write output_size, then read it back
  task automatic set_output_size(logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_OUTPUT_SIZE;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Literal run of n bytes (1..32); the first control byte gets junk in its top bits
  task automatic send_literals(int unsigned n, bit last);
    logic [7:0] ctrl;
    ctrl = first_token ? {3'($urandom), 5'(n - 1)} : 8'(n - 1);
    first_token = 1'b0;
    send_word(OP_BYTE, ctrl, 1'b0);
    for (int unsigned i = 0; i < n; i++)
      send_word(OP_BYTE, 8'($urandom), last && (i == n - 1));
    produced += n;
  endtask

  // Match token of total length len at distance back_dist, then the given number of copies
  task automatic send_match(int unsigned len, int unsigned back_dist, bit last,
                            int unsigned copies);
    logic [2:0]  lf;
    logic [4:0]  hi5;
    logic [15:0] far;
    int unsigned ext;
    lf  = (len <= 8) ? 3'(len - 2) : 3'd7;
    hi5 = (back_dist >= 8192) ? 5'd31 : 5'((back_dist - 1) >> 8);
    send_word(OP_BYTE, {lf, hi5}, 1'b0);
    if (lf == 3'd7) begin
      ext = len - 9;
      while (ext >= 255) begin
        send_word(OP_BYTE, BYTE_ALL1, 1'b0);
        ext -= 255;
      end
      send_word(OP_BYTE, 8'(ext), 1'b0);
    end
    if (back_dist >= 8192) begin
      far = 16'(back_dist - 8192);
      send_word(OP_BYTE, BYTE_ALL1, 1'b0);
      send_word(OP_BYTE, far[15:8], 1'b0);
      send_word(OP_BYTE, far[7:0], last);
    end else begin
      send_word(OP_BYTE, 8'((back_dist - 1) & 8'hFF), last);
    end
    for (int unsigned i = 0; i < copies; i++)
      send_word(OP_COPY, 8'($urandom), 1'($urandom));
    produced += copies;
  endtask

  initial begin
    int unsigned next_cfg;
    int unsigned n;
    int unsigned len;
    int unsigned back_dist;
    int unsigned reach;
    int unsigned k;
    int unsigned roll;
    ending_e     ending;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_output_size(32'h0000_0000);
    set_output_size(32'hFFFF_FFFF);

    // Directed opening: masked first control, byte extremes, overlap at distance one,
    // a chained length with a zero extension byte, a reach back to the first byte
    send_word(OP_BYTE, 8'hE2, 1'b0);
    send_word(OP_BYTE, 8'h00, 1'b0);
    send_word(OP_BYTE, 8'hFF, 1'b0);
    send_word(OP_BYTE, 8'h5A, 1'b0);
    produced = 3;
    first_token = 1'b0;
    send_literals(1, 1'b0);
    send_match(3, 1, 1'b0, 3);
    send_match(9, produced, 1'b0, 9);

    // Random stream of well-formed tokens
    next_cfg = 450;
    while (n_sent < 1300) begin
      quiet = (n_sent >= 500 && n_sent < 700);
      if (n_sent >= next_cfg) begin
        wait_drained();
        set_output_size(32'h8000_0000 | $urandom);
        next_cfg += 450;
      end
      reach = (produced < 8191) ? produced : 8191;
      if ($urandom_range(99) < 45) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(32, 17) : $urandom_range(8, 1);
        send_literals(n, 1'b0);
      end else begin
        roll = $urandom_range(39);
        if (roll == 0) len = 9 + $urandom_range(300, 255);
        else if (roll < 8) len = $urandom_range(30, 9);
        else len = $urandom_range(8, 3);
        roll = $urandom_range(9);
        if (roll < 3) back_dist = 1;
        else if (roll < 5) back_dist = reach;
        else back_dist = $urandom_range(reach, 1);
        send_match(len, back_dist, 1'b0, len);
      end
    end
    quiet = 1'b0;

    // Stream ending, clean or broken
    wait_drained();
    ending = ending_e'($urandom_range(6));
    case (ending)
      END_DONE_LIT: begin
        n = $urandom_range(32, 1);
        set_output_size(produced + n);
        send_literals(n, 1'b1);
      end
      END_DONE_MATCH: begin
        len = $urandom_range(12, 3);
        set_output_size(produced + len);
        send_match(len, $urandom_range(produced < 8191 ? produced : 8191, 1), 1'b1, len);
      end
      END_SHORT: begin
        n = $urandom_range(32, 1);
        set_output_size(produced + n + $urandom_range(50, 1));
        send_literals(n, 1'b1);
      end
      END_OVERRUN: begin
        k = $urandom_range(5, 0);
        set_output_size(produced + k);
        if ($urandom_range(1)) send_literals($urandom_range(32, k + 1), 1'b0);
        else send_match($urandom_range(12, (k + 1 > 3) ? k + 1 : 3), 1, 1'b0, 3);
      end
      END_BAD_REF: begin
        if ($urandom_range(1) && produced < 8190) back_dist = $urandom_range(8191, produced + 1);
        else back_dist = $urandom_range(73727, (produced + 1 > 8192) ? produced + 1 : 8192);
        send_match($urandom_range(8, 3), back_dist, 1'b0, 2);
      end
      END_TRUNC: begin
        case ($urandom_range(3))
          0: send_word(OP_BYTE, 8'($urandom), 1'b1);
          1: begin
            send_word(OP_BYTE, 8'd3, 1'b0);
            send_word(OP_BYTE, 8'($urandom), 1'b0);
            send_word(OP_BYTE, 8'($urandom), 1'b1);
          end
          2: begin
            send_word(OP_BYTE, {3'd7, 5'd0}, 1'b0);
            send_word(OP_BYTE, BYTE_ALL1, 1'b1);
          end
          default: begin
            send_word(OP_BYTE, {3'd1, 5'd31}, 1'b0);
            send_word(OP_BYTE, BYTE_ALL1, 1'b0);
            send_word(OP_BYTE, 8'($urandom), 1'b1);
          end
        endcase
      end
      default: begin
        // wrong opcode, either a copy with nothing pending or a byte mid-copy
        if ($urandom_range(1)) begin
          send_word(OP_COPY, 8'($urandom), 1'($urandom));
        end else begin
          send_match(8, 1, 1'b0, 3);
          send_word(OP_BYTE, 8'($urandom), 1'($urandom));
        end
      end
    endcase

    // Everything after the end is ignored
    repeat (40) send_word(1'($urandom), 8'($urandom), 1'($urandom));
    wait_drained();
    set_output_size(32'h0000_0000);
    repeat (10) send_word(1'($urandom), 8'($urandom), 1'($urandom));
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
